// File: design/bbc_pkg.sv
// Package for the buffer cache tag block: constants, codes and item types.
`default_nettype none
package bbc_pkg;
  localparam int NUM_BUFFERS_DEF = 32;
  localparam int REF_BITS_DEF = 8;

  localparam logic [1:0] FUNC_GET     = 2'd0;
  localparam logic [1:0] FUNC_VALID   = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NONE_FREE = 2'd1;
  localparam logic [1:0] ST_UNREF     = 2'd2;
  localparam logic [1:0] ST_SAT       = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  device;
    logic [31:0] sector;
    logic [4:0]  buf_index;
  } req_t;

  typedef struct packed {
    logic [4:0] slot;
    logic       hit;
    logic       needs_read;
    logic [1:0] status;
  } rsp_t;
endpackage
`default_nettype wire

// File: design/block_buffer_cache_lru.sv
// Top level of the buffer cache tag block with reference counts and LRU reuse.
`default_nettype none
// One request item is taken when start is high and busy is low. Its result
// appears for one cycle with done high and cannot be held off. After reset the
// block writes the initial LRU stamps, with busy high. A get scans the tag
// memory one entry a cycle, then goes through S_LAST to S_DONE. Mark valid,
// release and the unused code go through S_READ and S_WAIT to S_DONE.
// Busy falls with done, so the next item can be taken at the edge that ends the
// done cycle. The LRU order is kept as a release stamp per entry in the same
// memory: a miss takes the unreferenced tagged-or-untagged entry with the oldest
// stamp, found during the scan.
module block_buffer_cache_lru #(
  parameter int NUM_BUFFERS = bbc_pkg::NUM_BUFFERS_DEF,
  parameter int REF_BITS    = bbc_pkg::REF_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire bbc_pkg::req_t req,
  output logic              busy,
  output logic              done,
  output bbc_pkg::rsp_t     rsp
);
  import bbc_pkg::*;

  localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CW = $clog2(NUM_BUFFERS + 1);
  // Stamps grow by one per release that frees an entry; wrap takes 2^40-NUM_BUFFERS-1 of them.
  localparam int SW = 40;
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  typedef struct packed {
    logic [7:0]          dev;
    logic [31:0]         sec;
    logic                has_tag;
    logic                cvalid;
    logic [REF_BITS-1:0] cnt;
    logic [SW-1:0]       stamp;
  } ent_t;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_READ, S_WAIT, S_DONE} st_t;

  ent_t mem [NUM_BUFFERS];
  ent_t rd;
  logic [IW-1:0] raddr, waddr;
  logic          we;
  ent_t          wd;

  st_t           st;
  req_t          cur;
  logic [CW-1:0] scan;
  logic [CW-1:0] free_count;
  logic [SW-1:0] clock_stamp;
  logic          found, have_vic, scan_v;
  logic [IW-1:0] hit_i, vic_i, scan_i;
  ent_t          hit_e;
  logic [SW-1:0] vic_stamp;
  logic [CW-1:0] init_cnt;
  rsp_t          rsp_next;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wd;
    rd <= mem[raddr];
  end

  // Reset stamps: slot i must look older the higher its index.
  logic init_we;
  always_comb begin
    we    = 1'b0;
    waddr = IW'(cur.buf_index);
    wd    = rd;
    if (init_we) begin
      we = 1'b1;
      waddr = init_cnt[IW-1:0];
      wd = '0;
      wd.stamp = SW'(NUM_BUFFERS) - SW'(init_cnt);
    end else if (st == S_DONE) begin
      if (cur.func == FUNC_GET) begin
        if (found) begin
          waddr = hit_i;
          wd = hit_e;
          if (hit_e.cnt != REF_MAX) begin
            wd.cnt = hit_e.cnt + 1'b1;
            we = 1'b1;
          end
        end else if (have_vic) begin
          we = 1'b1;
          waddr = vic_i;
          wd = '0;
          wd.dev = cur.device;
          wd.sec = cur.sector;
          wd.has_tag = 1'b1;
          wd.cnt = REF_BITS'(1);
        end
      end else if (cur.func == FUNC_VALID) begin
        we = (32'(cur.buf_index) < NUM_BUFFERS);
        wd.cvalid = 1'b1;
      end else if (cur.func == FUNC_RELEASE) begin
        we = (32'(cur.buf_index) < NUM_BUFFERS) && (rd.cnt != '0);
        wd.cnt = rd.cnt - 1'b1;
        if (rd.cnt == REF_BITS'(1)) wd.stamp = clock_stamp;
      end
    end
  end

  // While idle the first entry is read, ready for the scan of a get.
  always_comb begin
    raddr = IW'(cur.buf_index);
    if (st == S_IDLE) raddr = '0;
    else if (st == S_SCAN) raddr = scan[IW-1:0];
  end

  always_comb begin
    rsp_next = '0;
    rsp_next.slot = cur.buf_index;
    if (cur.func == FUNC_GET) begin
      if (found) begin
        rsp_next.slot = 5'(hit_i);
        rsp_next.hit = 1'b1;
        rsp_next.needs_read = !hit_e.cvalid;
        if (hit_e.cnt == REF_MAX) rsp_next.status = ST_SAT;
      end else if (!have_vic) begin
        rsp_next.slot = '0;
        rsp_next.status = ST_NONE_FREE;
      end else begin
        rsp_next.slot = 5'(vic_i);
        rsp_next.needs_read = 1'b1;
      end
    end else if (cur.func == FUNC_RELEASE) begin
      if (!(32'(cur.buf_index) < NUM_BUFFERS) || rd.cnt == '0)
        rsp_next.status = ST_UNREF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      busy <= 1'b1;
      done <= 1'b0;
      init_we <= 1'b1;
      init_cnt <= '0;
      free_count <= CW'(NUM_BUFFERS);
      clock_stamp <= SW'(NUM_BUFFERS) + SW'(1);
      scan <= '0;
      scan_v <= 1'b0;
    end else if (init_we) begin
      done <= 1'b0;
      if (init_cnt == CW'(NUM_BUFFERS - 1)) begin
        init_we <= 1'b0;
        busy <= 1'b0;
      end
      init_cnt <= init_cnt + 1'b1;
    end else begin
      done <= (st == S_DONE);
      case (st)
        S_IDLE: if (start) begin
          cur <= req;
          busy <= 1'b1;
          found <= 1'b0;
          have_vic <= 1'b0;
          if (req.func == FUNC_GET) begin
            st <= S_SCAN;
            scan <= CW'(1);
            scan_i <= '0;
            scan_v <= 1'b1;
          end else begin
            scan <= '0;
            st <= S_READ;
          end
        end
        S_SCAN, S_LAST: begin
          // rd holds entry scan_i read in the previous cycle.
          if (scan_v) begin
            if (!found && rd.has_tag && rd.dev == cur.device && rd.sec == cur.sector) begin
              found <= 1'b1;
              hit_i <= scan_i;
              hit_e <= rd;
            end
            if (rd.cnt == '0 && (!have_vic || rd.stamp < vic_stamp)) begin
              have_vic <= 1'b1;
              vic_i <= scan_i;
              vic_stamp <= rd.stamp;
            end
          end
          scan_i <= scan[IW-1:0];
          if (st == S_LAST) begin
            st <= S_DONE;
          end else if (scan == CW'(NUM_BUFFERS)) begin
            scan_v <= 1'b0;
            st <= S_LAST;
          end else scan <= scan + 1'b1;
        end
        S_READ: st <= S_WAIT;
        S_WAIT: st <= S_DONE;
        S_DONE: begin
          st <= S_IDLE;
          busy <= 1'b0;
          rsp <= rsp_next;
          if (cur.func == FUNC_GET) begin
            if (found) begin
              if (hit_e.cnt == '0) free_count <= free_count - 1'b1;
            end else if (have_vic) begin
              free_count <= free_count - 1'b1;
            end
          end else if (cur.func == FUNC_RELEASE && (32'(cur.buf_index) < NUM_BUFFERS)
                       && rd.cnt == REF_BITS'(1)) begin
            free_count <= free_count + 1'b1;
            clock_stamp <= clock_stamp + 1'b1;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Reads for mark valid and release settle on S_WAIT; only the index matters.
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");
  a_busy_scan: assert property (@(posedge clk) disable iff (rst)
    (st != S_IDLE) |-> busy) else $error("busy low while a request is in work");
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    free_count <= CW'(NUM_BUFFERS)) else $error("free count beyond buffer count");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");
endmodule
`default_nettype wire

// File: verif/bbc_checker.sv
// Checker for the buffer cache tag block: predicts each result and compares it.
`timescale 1ns / 1ps
module bbc_checker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire bbc_pkg::req_t req,
  input  wire logic          done,
  input  wire bbc_pkg::rsp_t rsp,
  output int                 errors,
  output int                 pending
);
  import bbc_pkg::*;
  localparam int NB = 32;
  localparam int CNT_MAX = 255;

  logic [7:0]  tag_dev [NB];
  logic [31:0] tag_sec [NB];
  logic        has_tag [NB];
  logic        filled  [NB];
  int          refs    [NB];
  int          free_list[$];   // position 0 is the newest released entry
  rsp_t        expected_q[$];

  function automatic rsp_t predict_cache(req_t r);
    rsp_t o;
    int hit_at;
    int v;
    o = '0;
    o.slot = r.buf_index;
    hit_at = -1;
    if (r.func == FUNC_GET) begin
      for (int i = 0; i < NB; i++)
        if (hit_at < 0 && has_tag[i] && tag_dev[i] == r.device && tag_sec[i] == r.sector)
          hit_at = i;
      if (hit_at >= 0) begin
        o.slot = hit_at[4:0];
        o.hit = 1'b1;
        o.needs_read = !filled[hit_at];
        if (refs[hit_at] >= CNT_MAX) begin
          o.status = ST_SAT;
        end else begin
          if (refs[hit_at] == 0)
            foreach (free_list[k])
              if (free_list[k] == hit_at) begin
                free_list.delete(k);
                break;
              end
          refs[hit_at]++;
        end
      end else if (free_list.size() == 0) begin
        o.slot = '0;
        o.status = ST_NONE_FREE;
      end else begin
        v = free_list.pop_back();
        tag_dev[v] = r.device;
        tag_sec[v] = r.sector;
        has_tag[v] = 1'b1;
        filled[v] = 1'b0;
        refs[v] = 1;
        o.slot = v[4:0];
        o.needs_read = 1'b1;
      end
    end else if (r.func == FUNC_VALID) begin
      filled[r.buf_index] = 1'b1;
    end else if (r.func == FUNC_RELEASE) begin
      if (refs[r.buf_index] == 0) begin
        o.status = ST_UNREF;
      end else begin
        refs[r.buf_index]--;
        if (refs[r.buf_index] == 0) free_list.push_front(int'(r.buf_index));
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      for (int i = 0; i < NB; i++) begin
        tag_dev[i] = '0; tag_sec[i] = '0; has_tag[i] = 0; filled[i] = 0; refs[i] = 0;
      end
      free_list.delete();
      for (int i = 0; i < NB; i++) free_list.push_back(i);
      expected_q.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, rsp);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (rsp.slot !== e.slot || rsp.hit !== e.hit || rsp.needs_read !== e.needs_read
              || rsp.status !== e.status) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, e, rsp);
            errors++;
          end
        end
      end
      if (start && !busy) expected_q.push_back(predict_cache(req));
    end
    pending = expected_q.size();
  end
endmodule

// File: verif/tb_block_buffer_cache_lru.sv
// Testbench top for the buffer cache tag block: stimulus and verdict.
`timescale 1ns / 1ps
module tb_block_buffer_cache_lru;
  import bbc_pkg::*;

  logic clk = 0, rst = 1, start = 0, busy, done;
  req_t req = '0;
  rsp_t rsp;
  int   errors, pending;
  int   cycles = 0;
  logic [7:0]  dev_pool [8];
  logic [31:0] sec_pool [8];

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  block_buffer_cache_lru dut (.clk, .rst, .start, .req, .busy, .done, .rsp);
  bbc_checker chk (.clk, .rst, .start, .busy, .req, .done, .rsp, .errors, .pending);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drive one item, hold it until the block takes it, then drop start for a cycle.
  task automatic send_item(logic [1:0] f, logic [7:0] d, logic [31:0] s, logic [4:0] b);
    req_t r;
    r.func = f; r.device = d; r.sector = s; r.buf_index = b;
    req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int p;
    int f;
    for (int i = 0; i < 8; i++) begin
      dev_pool[i] = 8'($urandom);
      sec_pool[i] = $urandom;
    end
    dev_pool[0] = 8'hFF; sec_pool[0] = 32'hFFFF_FFFF;
    dev_pool[1] = 8'h00; sec_pool[1] = 32'h0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: release of an unreferenced entry, func 3, extreme tags, hits.
    send_item(FUNC_RELEASE, 8'd0, 32'd0, 5'd31);
    send_item(2'd3, 8'hFF, 32'hFFFF_FFFF, 5'd17);
    send_item(FUNC_GET, 8'h00, 32'h0, 5'd0);
    send_item(FUNC_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
    send_item(FUNC_GET, 8'h00, 32'h0, 5'd0);
    send_item(FUNC_VALID, 8'd0, 32'd0, 5'd31);
    send_item(FUNC_GET, 8'h00, 32'h0, 5'd0);
    send_item(FUNC_RELEASE, 8'd0, 32'd0, 5'd31);
    send_item(FUNC_RELEASE, 8'd0, 32'd0, 5'd31);
    send_item(FUNC_RELEASE, 8'd0, 32'd0, 5'd31);
    send_item(FUNC_RELEASE, 8'd0, 32'd0, 5'd30);
    send_item(FUNC_GET, 8'h12, 32'h3456, 5'd0);
    // Fill every entry, then a get finds nothing free.
    for (int i = 0; i < 33; i++) send_item(FUNC_GET, 8'hA5, 32'(i), 5'd0);
    // Saturate one count.
    for (int i = 0; i < 256; i++) send_item(FUNC_GET, 8'hA5, 32'd3, 5'd0);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    for (int i = 0; i < 32; i++) send_item(FUNC_RELEASE, 8'd0, 32'd0, 5'(i));
    // Random: gets from a small pool of blocks so hits happen, with mark valid, releases and random codes.
    for (int i = 0; i < 220; i++) begin
      f = $urandom_range(0, 9);
      p = $urandom_range(0, 7);
      if (f < 4)
        send_item(FUNC_GET, dev_pool[p],
                  ($urandom_range(0, 3) == 0) ? $urandom : sec_pool[p], 5'd0);
      else if (f < 6)
        send_item(FUNC_VALID, 8'($urandom), $urandom, 5'($urandom));
      else if (f < 9)
        send_item(FUNC_RELEASE, 8'($urandom), $urandom, 5'($urandom));
      else
        send_item(2'($urandom), 8'($urandom), $urandom, 5'($urandom));
      if (i == 110) wait (pending == 0);
      random_gap();
    end
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: sim.f
design/bbc_pkg.sv
design/block_buffer_cache_lru.sv
verif/bbc_checker.sv
verif/tb_block_buffer_cache_lru.sv
